>>> design/slir_pkg.sv
package slir_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_RESOLVE,
    S_SHIFT,
    S_SHIFT_LAST,
    S_WRITE,
    S_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic probe;
    logic miss;
    logic compare;
    logic resolve;
    logic shift;
    logic shift_last;
    logic write_new;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic go;
    logic eq;
    logic insert_ok;
    logic need_shift;
    logic shift_end;
  } sts_t;

endpackage

>>> design/sorted_leaf_insert_lookup.sv
// Sorted leaf table: signed 32-bit keys paired with record ids, kept in
// ascending key order, as in one leaf of a B+ tree.
// Request channel: drive op_i (0 insert, 1 lookup), key_i and value_i and
// raise start; the request is taken at a clock edge with start high and
// busy low. busy stays high until the result has been shown.
// Result channel: done_o is high for exactly one cycle with found_o,
// position_o, value_out_o, count_o and full_res_o. The receiver cannot
// stall it; capture the result in that cycle.
// Sequence, from the accepting cycle through the result cycle: a load
// step, then per binary-search probe a registered memory read and then a
// compare, a miss step when the search ends without a match, a resolve
// step, then for an insert the entries above the insertion point moved up
// one at a time from the top, a write of the last one moved and a write of
// the new entry (only the new entry's write when nothing moves), then the
// result. A lookup or a refused insert goes from the resolve step straight
// to the result. The single write port of the key and value memories, one
// entry per cycle, sets the insert time. One request at a time. Reset
// clears the entry count and the controller only; the memories are not
// cleared, and entries at or above the count are never used.
module sorted_leaf_insert_lookup #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic signed [31:0]    key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [8:0]            position_o,
  output logic [VALUE_BITS-1:0] value_out_o,
  output logic [8:0]            count_o,
  output logic                  full_res_o
);

  slir_pkg::cmd_t cmd;
  slir_pkg::sts_t sts;

  // Sequence search, shift and write
  slir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // Hold key/value memories, search bounds and result registers
  slir_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (op_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .found_o     (found_o),
    .position_o  (position_o),
    .value_out_o (value_out_o),
    .count_o     (count_o),
    .full_res_o  (full_res_o)
  );

endmodule

>>> design/slir_ram.sv
module slir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/slir_ctrl.sv
module slir_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  slir_pkg::sts_t     sts_i,
  output slir_pkg::cmd_t     cmd_o,
  output logic               busy,
  output logic               done_o
);

  slir_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slir_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      slir_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = slir_pkg::S_PROBE;
        end
      end
      slir_pkg::S_PROBE: begin
        if (sts_i.go) begin
          cmd_o.probe = 1'b1;
          state_d     = slir_pkg::S_CMP;
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = slir_pkg::S_RESOLVE;
        end
      end
      slir_pkg::S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = sts_i.eq ? slir_pkg::S_RESOLVE : slir_pkg::S_PROBE;
      end
      slir_pkg::S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        if (!sts_i.insert_ok) begin
          state_d = slir_pkg::S_DONE;
        end else if (sts_i.need_shift) begin
          state_d = slir_pkg::S_SHIFT;
        end else begin
          state_d = slir_pkg::S_WRITE;
        end
      end
      slir_pkg::S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_end) begin
          state_d = slir_pkg::S_SHIFT_LAST;
        end
      end
      slir_pkg::S_SHIFT_LAST: begin
        cmd_o.shift_last = 1'b1;
        state_d          = slir_pkg::S_WRITE;
      end
      slir_pkg::S_WRITE: begin
        cmd_o.write_new = 1'b1;
        state_d         = slir_pkg::S_DONE;
      end
      slir_pkg::S_DONE: begin
        state_d = slir_pkg::S_IDLE;
      end
      default: begin
        state_d = slir_pkg::S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != slir_pkg::S_IDLE);
  assign done_o = (state_q == slir_pkg::S_DONE);

endmodule

>>> design/slir_dp.sv
module slir_dp #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slir_pkg::cmd_t        cmd_i,
  output slir_pkg::sts_t        sts_o,
  input  logic                  op_i,
  input  logic signed [31:0]    key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  found_o,
  output logic [8:0]            position_o,
  output logic [VALUE_BITS-1:0] value_out_o,
  output logic [8:0]            count_o,
  output logic                  full_res_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic                  op_q;
  logic signed [31:0]    key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         lo_q, hie_q, pos_q, count_q;
  logic [AW-1:0]         ptr_q;
  logic                  shift_wr_q;
  logic                  found_q, full_q;
  logic [VALUE_BITS-1:0] vout_q;

  logic [CW:0]           sum;
  logic [AW-1:0]         mid;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;
  logic [31:0]           krdata, kwdata;
  logic [VALUE_BITS-1:0] vrdata, vwdata;

  // Midpoint of lo..hi, with hi kept one above the last live index
  assign sum = {1'b0, lo_q} + {1'b0, hie_q} - (CW + 1)'(1);
  assign mid = sum[AW:1];

  assign raddr = cmd_i.probe ? mid : ptr_q;
  assign we    = (cmd_i.shift && shift_wr_q) || cmd_i.shift_last || cmd_i.write_new;

  always_comb begin
    if (cmd_i.write_new) begin
      waddr = pos_q[AW-1:0];
    end else if (cmd_i.shift_last) begin
      waddr = AW'({1'b0, ptr_q} + (AW + 1)'(1));
    end else begin
      waddr = AW'({1'b0, ptr_q} + (AW + 1)'(2));
    end
  end

  assign kwdata = cmd_i.write_new ? key_q : krdata;
  assign vwdata = cmd_i.write_new ? val_q : vrdata;

  slir_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (kwdata),
    .raddr_i (raddr),
    .rdata_o (krdata)
  );

  slir_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (vwdata),
    .raddr_i (raddr),
    .rdata_o (vrdata)
  );

  assign sts_o.go         = (lo_q < hie_q);
  assign sts_o.eq         = (krdata == key_q);
  assign sts_o.insert_ok  = !op_q && (count_q < CW'(CAPACITY));
  assign sts_o.need_shift = (count_q > pos_q);
  assign sts_o.shift_end  = (CW'(ptr_q) == pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.write_new) begin
      count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      key_q   <= key_i;
      val_q   <= value_i;
      lo_q    <= '0;
      hie_q   <= count_q;
      found_q <= 1'b0;
      full_q  <= 1'b0;
      vout_q  <= '0;
    end
    if (cmd_i.miss) begin
      pos_q <= lo_q;
    end
    if (cmd_i.compare) begin
      if (sts_o.eq) begin
        found_q <= 1'b1;
        pos_q   <= CW'(mid);
        vout_q  <= vrdata;
      end else if ($signed(krdata) < key_q) begin
        lo_q <= CW'(mid) + CW'(1);
      end else begin
        hie_q <= CW'(mid);
      end
    end
    if (cmd_i.resolve) begin
      full_q     <= !op_q && !(count_q < CW'(CAPACITY));
      ptr_q      <= AW'(count_q - CW'(1));
      shift_wr_q <= 1'b0;
    end
    if (cmd_i.shift) begin
      shift_wr_q <= 1'b1;
      if (!sts_o.shift_end) begin
        ptr_q <= ptr_q - AW'(1);
      end
    end
  end

  assign found_o     = found_q;
  assign position_o  = 9'(pos_q);
  assign value_out_o = vout_q;
  assign count_o     = 9'(count_q);
  assign full_res_o  = full_q;

endmodule

>>> design/slir_chk.sv
module slir_chk #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 64
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  op_i,
  input logic signed [31:0]    key_i,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  done_o,
  input logic                  found_o,
  input logic [8:0]            position_o,
  input logic [VALUE_BITS-1:0] value_out_o,
  input logic [8:0]            count_o,
  input logic                  full_res_o
);

  // An accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // The result strobe ends the request
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("block still busy after result");

  // A refused insert reports a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && full_res_o |-> count_o == 9'(CAPACITY))
    else $error("full flag with table not full");

  // No match, no value
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> value_out_o == '0)
    else $error("value reported without a match");

endmodule

bind sorted_leaf_insert_lookup slir_chk #(
  .CAPACITY   (CAPACITY),
  .VALUE_BITS (VALUE_BITS)
) u_slir_chk (.*);

>>> dv/leaf_table_checker.sv
package leaf_tb_pkg;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
endpackage

module leaf_table_checker #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  op_i,
  input  logic signed [31:0]    key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  done_o,
  input  logic                  found_o,
  input  logic [8:0]            position_o,
  input  logic [VALUE_BITS-1:0] value_out_o,
  input  logic [8:0]            count_o,
  input  logic                  full_res_o,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    hit_count_o,
  output int                    refused_count_o
);
  import leaf_tb_pkg::*;

  localparam int REPORT_LIMIT = 20;

  typedef struct packed {
    logic                  found;
    logic [8:0]            position;
    logic [VALUE_BITS-1:0] value_out;
    logic [8:0]            count;
    logic                  full;
  } leaf_result_t;

  logic signed [31:0]    leaf_keys   [CAPACITY];
  logic [VALUE_BITS-1:0] leaf_values [CAPACITY];
  int                    leaf_count;
  leaf_result_t          pending_results[$];

  // Run the midpoint search over the occupied entries, then apply an insert.
  function automatic leaf_result_t search_and_update(input logic op,
                                                     input logic signed [31:0] k,
                                                     input logic [VALUE_BITS-1:0] v);
    leaf_result_t r;
    int lo;
    int hi;
    int mid;
    int i;
    bit hit;
    r   = '0;
    lo  = 0;
    hi  = leaf_count - 1;
    hit = 1'b0;
    while (lo <= hi && !hit) begin
      mid = (lo + hi) / 2;
      if (leaf_keys[mid] == k) begin
        hit = 1'b1;
        lo  = mid;
      end else if (leaf_keys[mid] < k) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    r.found     = hit;
    r.position  = lo[8:0];
    r.value_out = hit ? leaf_values[lo] : '0;
    if (op == OP_INSERT) begin
      if (leaf_count >= CAPACITY) begin
        r.full = 1'b1;
      end else begin
        for (i = leaf_count; i > lo; i--) begin
          leaf_keys[i]   = leaf_keys[i-1];
          leaf_values[i] = leaf_values[i-1];
        end
        leaf_keys[lo]   = k;
        leaf_values[lo] = v;
        leaf_count++;
      end
    end
    r.count = leaf_count[8:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    leaf_result_t want;
    if (!rst_ni) begin
      leaf_count = 0;
      pending_results.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      hit_count_o     = 0;
      refused_count_o = 0;
    end else begin
      // Retire the result first: a new request cannot produce one on its own edge.
      if (done_o) begin
        if (pending_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding: found=%0b pos=%0d value=%h count=%0d full=%0b",
                     $time, found_o, position_o, value_out_o, count_o, full_res_o);
        end else begin
          want = pending_results.pop_front();
          if (want.found !== found_o || want.position !== position_o ||
              want.value_out !== value_out_o || want.count !== count_o ||
              want.full !== full_res_o) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected found=%0b pos=%0d value=%h count=%0d full=%0b",
                       want.found, want.position, want.value_out, want.count, want.full);
              $display("  actual   found=%0b pos=%0d value=%h count=%0d full=%0b",
                       found_o, position_o, value_out_o, count_o, full_res_o);
            end
          end
        end
      end
      if (start && !busy) begin
        want = search_and_update(op_i, key_i, value_i);
        hit_count_o     += want.found;
        refused_count_o += want.full;
        pending_results.push_back(want);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

>>> dv/tb_sorted_leaf_insert_lookup.sv
module tb_sorted_leaf_insert_lookup;
  import leaf_tb_pkg::*;

  localparam int CAPACITY        = 256;
  localparam int VALUE_BITS      = 64;
  // Random part after the directed requests; roughly 30% inserts fill the
  // table about halfway through, so the rest exercises refused inserts.
  localparam int RANDOM_REQUESTS = 1580;
  localparam int INSERT_PERCENT  = 30;
  // Allow several times a full shift plus the longest sender gap before
  // calling the run hung.
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 300;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  op_i;
  logic signed [31:0]    key_i;
  logic [VALUE_BITS-1:0] value_i;
  logic                  done_o;
  logic                  found_o;
  logic [8:0]            position_o;
  logic [VALUE_BITS-1:0] value_out_o;
  logic [8:0]            count_o;
  logic                  full_res_o;

  int fail_count;
  int pending;
  int hit_count;
  int refused_count;
  int insert_count = 0;
  int lookup_count = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;

  // Keys inserted so far; reused to hit existing entries and to stack duplicates.
  logic signed [31:0] issued_keys[$];

  sorted_leaf_insert_lookup #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .key_i      (key_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .found_o    (found_o),
    .position_o (position_o),
    .value_out_o(value_out_o),
    .count_o    (count_o),
    .full_res_o (full_res_o)
  );

  leaf_table_checker #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .position_o     (position_o),
    .value_out_o    (value_out_o),
    .count_o        (count_o),
    .full_res_o     (full_res_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .hit_count_o    (hit_count),
    .refused_count_o(refused_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: count cycles with neither a request nor a result accepted.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pick the idle time before the next request: mostly back to back or short,
  // now and then long, with occasional bursts of back-to-back requests.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Draw a key: extremes, keys already sent, their neighbors, a narrow band
  // around zero for dense duplicates, or any 32-bit pattern.
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 6))
        0: return KEY_MIN;
        1: return KEY_MIN + 1;
        2: return -1;
        3: return 0;
        4: return 1;
        5: return KEY_MAX - 1;
        default: return KEY_MAX;
      endcase
    end
    if (r < 45 && issued_keys.size() > 0)
      return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    if (r < 55 && issued_keys.size() > 0)
      return issued_keys[$urandom_range(0, issued_keys.size() - 1)] +
             ($urandom_range(0, 1) ? 1 : -1);
    if (r < 70) return $signed($urandom_range(0, 40)) - 20;
    return $urandom;
  endfunction

  // Called at a falling edge. Idle for a random gap, present the request,
  // hold it until the block takes it, and return at the next falling edge.
  task automatic send_request(input logic op, input logic signed [31:0] k,
                              input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    key_i   <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    if (op == OP_INSERT) begin
      insert_count++;
      issued_keys.push_back(k);
    end else begin
      lookup_count++;
    end
    @(negedge clk_i);
  endtask

  initial begin
    int n;
    rst_ni  = 1'b0;
    start   = 1'b0;
    op_i    = OP_LOOKUP;
    key_i   = '0;
    value_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Search the empty table: insertion point zero, nothing found.
    send_request(OP_LOOKUP, 0, '1);
    send_request(OP_LOOKUP, KEY_MIN, '0);
    // Build a small table from the key extremes with patterned values.
    send_request(OP_INSERT, 0, '1);
    send_request(OP_INSERT, KEY_MAX, '0);
    send_request(OP_INSERT, KEY_MIN, 64'h8000_0000_0000_0001);
    send_request(OP_INSERT, -1, 64'h5555_5555_5555_5555);
    send_request(OP_INSERT, 1, 64'hAAAA_AAAA_AAAA_AAAA);
    // Duplicates in the middle and at both ends go ahead of the equal key.
    send_request(OP_INSERT, 0, 64'h0123_4567_89AB_CDEF);
    send_request(OP_INSERT, KEY_MAX, {$urandom, $urandom});
    send_request(OP_INSERT, KEY_MIN, {$urandom, $urandom});
    // Probe every stored key and the gaps between them; the value is ignored.
    send_request(OP_LOOKUP, KEY_MIN, {$urandom, $urandom});
    send_request(OP_LOOKUP, KEY_MIN + 1, {$urandom, $urandom});
    send_request(OP_LOOKUP, -2, {$urandom, $urandom});
    send_request(OP_LOOKUP, -1, {$urandom, $urandom});
    send_request(OP_LOOKUP, 0, {$urandom, $urandom});
    send_request(OP_LOOKUP, 1, {$urandom, $urandom});
    send_request(OP_LOOKUP, 2, {$urandom, $urandom});
    send_request(OP_LOOKUP, KEY_MAX - 1, {$urandom, $urandom});
    send_request(OP_LOOKUP, KEY_MAX, {$urandom, $urandom});

    // Random mix: the table fills, then inserts keep coming and get refused.
    for (n = 0; n < RANDOM_REQUESTS; n++)
      send_request(($urandom_range(0, 99) < INSERT_PERCENT) ? OP_INSERT : OP_LOOKUP,
                   pick_key(), {$urandom, $urandom});
    start <= 1'b0;

    // Drain outstanding results, then watch for anything extra.
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d requests (%0d inserts, %0d lookups): %0d key hits, %0d inserts refused on a full table",
             insert_count + lookup_count, insert_count, lookup_count, hit_count, refused_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d results failed", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
